>>> rtl/lsti_pkg.sv
// Shared types and constants for the L-system turtle interpreter.
package lsti_pkg;

   // Field widths of the streams and the register port.
   localparam int SYMBOL_W    = 8;
   localparam int ACTION_W    = 3;
   localparam int COORD_OUT_W = 16;
   localparam int HEADING_W   = 9;
   localparam int LETTER_W    = 8;
   localparam int LEVEL_W     = 7;
   localparam int STEP_W      = 10;
   localparam int TURN_W      = 9;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 10;

   // Defaults for the top-level parameters.
   localparam int STACK_DEPTH_DEF        = 64;
   localparam int COORD_WIDTH_DEF        = 16;
   localparam int SINE_FRACTION_BITS_DEF = 15;

   // Quarter-wave sine table geometry.
   localparam int SINE_ENTRIES = 91;
   localparam int SINE_IDX_W   = 7;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_LENGTH = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TURN_ANGLE  = 1'd1;

   // Register values after reset.
   localparam logic [STEP_W-1:0] STEP_RESET = 10'd10;
   localparam logic [TURN_W-1:0] TURN_RESET = 9'd90;

   // Angles in whole degrees.
   localparam logic [HEADING_W-1:0] DEG_90  = 9'd90;
   localparam logic [HEADING_W-1:0] DEG_180 = 9'd180;
   localparam logic [HEADING_W-1:0] DEG_270 = 9'd270;
   localparam logic [HEADING_W-1:0] DEG_360 = 9'd360;

   // Character codes of the command string.
   localparam logic [SYMBOL_W-1:0] SYM_A     = 8'h41;
   localparam logic [SYMBOL_W-1:0] SYM_F     = 8'h46;
   localparam logic [SYMBOL_W-1:0] SYM_G     = 8'h47;
   localparam logic [SYMBOL_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYMBOL_W-1:0] SYM_MINUS = 8'h2D;
   localparam logic [SYMBOL_W-1:0] SYM_OPEN  = 8'h5B;
   localparam logic [SYMBOL_W-1:0] SYM_CLOSE = 8'h5D;

   // Result action codes.
   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE      = 3'd0,
      ACT_DRAW      = 3'd1,
      ACT_MOVE      = 3'd2,
      ACT_OVERFLOW  = 3'd3,
      ACT_UNDERFLOW = 3'd4
   } action_type;

   // Result item layout, first field in the lowest bits.
   localparam int RSP_FIELDS_W = ACTION_W + 4 * COORD_OUT_W + HEADING_W + LETTER_W + LEVEL_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   typedef struct packed {
      logic [RSP_PAD_W-1:0]   pad;
      logic [LEVEL_W-1:0]     stack_level;
      logic [LETTER_W-1:0]    segment_letter;
      logic [HEADING_W-1:0]   heading_deg;
      logic [COORD_OUT_W-1:0] to_y;
      logic [COORD_OUT_W-1:0] to_x;
      logic [COORD_OUT_W-1:0] from_y;
      logic [COORD_OUT_W-1:0] from_x;
      action_type             action;
   } rsp_data_type;

endpackage

>>> rtl/lsti_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module lsti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; the read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lsystem_turtle_interpreter.sv
// Top level of the L-system turtle interpreter: decode, step, turn and bracket stack.
//
// Usage: one command symbol enters per transfer on the req_ channel (tdata holds the
// 8-bit symbol). Every symbol gives exactly one result transfer on the rsp_ channel,
// in order. The csr_ port writes step_length (index 0) and turn_angle_deg (index 1);
// write it only while no symbol is in flight.
//
// Stages: a symbol accepted on req_ enters the input stage, moves into the second
// stage and then into the output register that drives rsp_tvalid. A symbol computes
// its step from the heading and reads the stack memory as it leaves the input stage,
// and commits position, heading and stack pointer in the second stage. The next symbol
// leaves the input stage only after that commit, so it can wait there while the one
// ahead of it is still in the second stage. The stack memory has a registered read, so
// a pop reads as it leaves the input stage and uses the data in the second stage.
//
// Reset clears position, heading, stack pointer, the registers to their defaults and
// all valid flags; the stack memory itself is not cleared. When the receiver holds
// rsp_tready low the result waits in the output register; one more symbol can still
// advance into the second stage and one more is taken into the input stage before
// req_tready drops.
module lsystem_turtle_interpreter
   import lsti_pkg::*;
#(
   parameter int STACK_DEPTH        = STACK_DEPTH_DEF,
   parameter int COORD_WIDTH        = COORD_WIDTH_DEF,
   parameter int SINE_FRACTION_BITS = SINE_FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Symbol stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SYMBOL_W-1:0]   req_tdata,   // [7:0] symbol
   // Result stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] action, [18:3] from_x, [34:19] from_y, [50:35] to_x, [66:51] to_y,
   // [75:67] heading_deg, [83:76] segment_letter, [90:84] stack_level, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Register write port.
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SINE_W    = SINE_FRACTION_BITS + 1;
   localparam int SINE_SH   = 30 - SINE_FRACTION_BITS;
   localparam int PROD_W    = STEP_W + SINE_W;
   localparam int DELTA_W   = STEP_W + 1;
   localparam int SUM_W     = ((COORD_WIDTH > DELTA_W) ? COORD_WIDTH : DELTA_W) + 1;
   localparam int SP_W      = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int ENTRY_W   = 2 * COORD_WIDTH + HEADING_W;
   localparam longint PI_Q30 = 64'sd3373259426;
   localparam logic signed [SUM_W-1:0] SAT_HI =
      SUM_W'((longint'(1) <<< (COORD_WIDTH - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO =
      SUM_W'(-(longint'(1) <<< (COORD_WIDTH - 1)));
   localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);
   localparam logic [HEADING_W:0] FULL_TURN = (HEADING_W + 1)'(360);

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_DRAW,
      CMD_MOVE,
      CMD_TURN_POS,
      CMD_TURN_NEG,
      CMD_PUSH,
      CMD_POP
   } cmd_type;

   typedef struct packed {
      logic                  neg;
      logic [SINE_IDX_W-1:0] idx;
   } fold_type;

   // Sine of d degrees, rounded to SINE_FRACTION_BITS, from a Q30 Taylor series.
   function automatic longint sine_entry(input int d);
      longint x;
      longint x2;
      longint term;
      longint sum;
      longint v;
      x    = (longint'(d) * PI_Q30 + 90) / 180;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >>> 30) / 6;   sum = sum - term;
      term = ((term * x2) >>> 30) / 20;  sum = sum + term;
      term = ((term * x2) >>> 30) / 42;  sum = sum - term;
      term = ((term * x2) >>> 30) / 72;  sum = sum + term;
      term = ((term * x2) >>> 30) / 110; sum = sum - term;
      term = ((term * x2) >>> 30) / 156; sum = sum + term;
      term = ((term * x2) >>> 30) / 210; sum = sum - term;
      term = ((term * x2) >>> 30) / 272; sum = sum + term;
      term = ((term * x2) >>> 30) / 342; sum = sum - term;
      term = ((term * x2) >>> 30) / 420; sum = sum + term;
      if (sum < 0) begin
         sum = 0;
      end
      v = (sum + (longint'(1) <<< (SINE_SH - 1))) >>> SINE_SH;
      if (v > (longint'(1) <<< SINE_FRACTION_BITS)) begin
         v = longint'(1) <<< SINE_FRACTION_BITS;
      end
      return v;
   endfunction

   // Fold a heading into the first quadrant and a sign.
   function automatic fold_type fold_angle(input logic [HEADING_W-1:0] a);
      fold_type f;
      f.neg = 1'b0;
      f.idx = '0;
      priority if (a <= DEG_90) begin
         f.idx = SINE_IDX_W'(a);
      end else if (a <= DEG_180) begin
         f.idx = SINE_IDX_W'(DEG_180 - a);
      end else if (a <= DEG_270) begin
         f.neg = 1'b1;
         f.idx = SINE_IDX_W'(a - DEG_180);
      end else begin
         f.neg = 1'b1;
         f.idx = SINE_IDX_W'(DEG_360 - a);
      end
      return f;
   endfunction

   // Map a symbol to its command.
   function automatic cmd_type decode_symbol(input logic [SYMBOL_W-1:0] sym);
      cmd_type c;
      if (sym >= SYM_A && sym <= SYM_F) begin
         c = CMD_DRAW;
      end else begin
         unique case (sym)
            SYM_G:     c = CMD_MOVE;
            SYM_PLUS:  c = CMD_TURN_POS;
            SYM_MINUS: c = CMD_TURN_NEG;
            SYM_OPEN:  c = CMD_PUSH;
            SYM_CLOSE: c = CMD_POP;
            default:   c = CMD_NONE;
         endcase
      end
      return c;
   endfunction

   // Quarter-wave sine table.
   logic [SINE_W-1:0] sine_rom [0:SINE_ENTRIES-1];

   for (genvar d = 0; d < SINE_ENTRIES; d++) begin : g_sine
      assign sine_rom[d] = SINE_W'(sine_entry(d));
   end

   // Configuration registers.
   logic [STEP_W-1:0] step_ff;
   logic [TURN_W-1:0] turn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
         turn_ff <= TURN_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_STEP_LENGTH: step_ff <= csr_wdata[STEP_W-1:0];
            CSR_TURN_ANGLE:  turn_ff <= csr_wdata[TURN_W-1:0];
            default:         ;
         endcase
      end
   end

   // Turtle state, pipeline stages and the output register.
   logic signed [COORD_WIDTH-1:0] pos_x_ff, pos_x_in;
   logic signed [COORD_WIDTH-1:0] pos_y_ff, pos_y_in;
   logic [HEADING_W-1:0]          heading_ff, heading_in;
   logic [SP_W-1:0]               sp_ff, sp_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic [SYMBOL_W-1:0]           s1_sym_ff, s1_sym_in;
   logic                          s2_valid_ff, s2_valid_in;
   cmd_type                       s2_cmd_ff, s2_cmd_in;
   logic [SYMBOL_W-1:0]           s2_sym_ff, s2_sym_in;
   logic signed [DELTA_W-1:0]     s2_dx_ff, s2_dx_in;
   logic signed [DELTA_W-1:0]     s2_dy_ff, s2_dy_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_data_type                  rsp_data_ff, rsp_data_in;

   // Stack memory signals.
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   // Handshake and stage control.
   logic    req_xfer;
   logic    s1_adv;
   logic    commit;
   cmd_type s1_cmd;

   assign s1_cmd     = decode_symbol(s1_sym_ff);
   assign s1_adv     = s1_valid_ff && !s2_valid_ff;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_xfer   = req_tvalid && req_tready;
   assign commit     = s2_valid_ff && (!rsp_valid_ff || rsp_tready);

   // Input stage and stage-one step computation from the committed heading.
   logic [HEADING_W:0]        cos_raw;
   logic [HEADING_W-1:0]      cos_angle;
   fold_type                  fold_s;
   fold_type                  fold_c;
   logic [PROD_W-1:0]         prod_s;
   logic [PROD_W-1:0]         prod_c;
   logic signed [DELTA_W-1:0] mag_s;
   logic signed [DELTA_W-1:0] mag_c;

   always_comb begin
      cos_raw   = {1'b0, heading_ff} + (HEADING_W + 1)'(DEG_90);
      cos_angle = (cos_raw >= FULL_TURN) ? HEADING_W'(cos_raw - FULL_TURN)
                                         : HEADING_W'(cos_raw);
      fold_s    = fold_angle(heading_ff);
      fold_c    = fold_angle(cos_angle);
      prod_s    = PROD_W'(step_ff) * PROD_W'(sine_rom[fold_s.idx]);
      prod_c    = PROD_W'(step_ff) * PROD_W'(sine_rom[fold_c.idx]);
      mag_s     = $signed({1'b0, prod_s[SINE_FRACTION_BITS +: STEP_W]});
      mag_c     = $signed({1'b0, prod_c[SINE_FRACTION_BITS +: STEP_W]});

      s1_valid_in = req_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_sym_in   = req_xfer ? req_tdata : s1_sym_ff;

      s2_valid_in = s1_adv ? 1'b1 : (commit ? 1'b0 : s2_valid_ff);
      s2_cmd_in   = s1_adv ? s1_cmd : s2_cmd_ff;
      s2_sym_in   = s1_adv ? s1_sym_ff : s2_sym_ff;
      s2_dx_in    = s2_dx_ff;
      s2_dy_in    = s2_dy_ff;
      if (s1_adv) begin
         s2_dx_in = fold_s.neg ? -mag_s : mag_s;
         s2_dy_in = fold_c.neg ? -mag_c : mag_c;
      end

      ram_rd_en   = s1_adv && (s1_cmd == CMD_POP) && (sp_ff != '0);
      ram_rd_addr = ADDR_W'(sp_ff - 1'b1);
   end

   // Commit stage: update the turtle and load the output register.
   logic signed [SUM_W-1:0]       sum_x;
   logic signed [SUM_W-1:0]       sum_y;
   logic signed [COORD_WIDTH-1:0] step_x;
   logic signed [COORD_WIDTH-1:0] step_y;
   logic [TURN_W-1:0]             turn_mod;
   logic [HEADING_W:0]            hdg_plus_raw;
   logic [HEADING_W:0]            hdg_minus_raw;
   logic [HEADING_W-1:0]          hdg_plus;
   logic [HEADING_W-1:0]          hdg_minus;
   action_type                    act;
   logic [LETTER_W-1:0]           letter;

   always_comb begin
      sum_x = SUM_W'(pos_x_ff) + SUM_W'(s2_dx_ff);
      sum_y = SUM_W'(pos_y_ff) + SUM_W'(s2_dy_ff);
      priority if (sum_x > SAT_HI) begin
         step_x = COORD_WIDTH'(SAT_HI);
      end else if (sum_x < SAT_LO) begin
         step_x = COORD_WIDTH'(SAT_LO);
      end else begin
         step_x = COORD_WIDTH'(sum_x);
      end
      priority if (sum_y > SAT_HI) begin
         step_y = COORD_WIDTH'(SAT_HI);
      end else if (sum_y < SAT_LO) begin
         step_y = COORD_WIDTH'(SAT_LO);
      end else begin
         step_y = COORD_WIDTH'(sum_y);
      end

      turn_mod      = (turn_ff >= DEG_360) ? TURN_W'(turn_ff - DEG_360) : turn_ff;
      hdg_plus_raw  = {1'b0, heading_ff} + {1'b0, turn_mod};
      hdg_minus_raw = {1'b0, heading_ff} + FULL_TURN - {1'b0, turn_mod};
      hdg_plus      = (hdg_plus_raw >= FULL_TURN) ? HEADING_W'(hdg_plus_raw - FULL_TURN)
                                                  : HEADING_W'(hdg_plus_raw);
      hdg_minus     = (hdg_minus_raw >= FULL_TURN) ? HEADING_W'(hdg_minus_raw - FULL_TURN)
                                                   : HEADING_W'(hdg_minus_raw);

      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      heading_in  = heading_ff;
      sp_in       = sp_ff;
      act         = ACT_NONE;
      letter      = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = sp_ff[ADDR_W-1:0];
      ram_wr_data = {pos_x_ff, pos_y_ff, heading_ff};

      if (commit) begin
         unique case (s2_cmd_ff)
            CMD_DRAW: begin
               pos_x_in = step_x;
               pos_y_in = step_y;
               act      = ACT_DRAW;
               letter   = s2_sym_ff;
            end
            CMD_MOVE: begin
               pos_x_in = step_x;
               pos_y_in = step_y;
               act      = ACT_MOVE;
            end
            CMD_TURN_POS: heading_in = hdg_plus;
            CMD_TURN_NEG: heading_in = hdg_minus;
            CMD_PUSH: begin
               if (sp_ff == SP_FULL) begin
                  act = ACT_OVERFLOW;
               end else begin
                  ram_wr_en = 1'b1;
                  sp_in     = sp_ff + 1'b1;
               end
            end
            CMD_POP: begin
               if (sp_ff == '0) begin
                  act = ACT_UNDERFLOW;
               end else begin
                  sp_in      = sp_ff - 1'b1;
                  pos_x_in   = ram_rd_data[ENTRY_W-1 -: COORD_WIDTH];
                  pos_y_in   = ram_rd_data[HEADING_W +: COORD_WIDTH];
                  heading_in = ram_rd_data[HEADING_W-1:0];
               end
            end
            default: ;
         endcase
      end

      rsp_valid_in = commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_data_ff;
      if (commit) begin
         rsp_data_in.pad            = '0;
         rsp_data_in.action         = act;
         rsp_data_in.from_x         = COORD_OUT_W'(pos_x_ff);
         rsp_data_in.from_y         = COORD_OUT_W'(pos_y_ff);
         rsp_data_in.to_x           = COORD_OUT_W'(pos_x_in);
         rsp_data_in.to_y           = COORD_OUT_W'(pos_y_in);
         rsp_data_in.heading_deg    = heading_in;
         rsp_data_in.segment_letter = letter;
         rsp_data_in.stack_level    = LEVEL_W'(sp_in);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= '0;
         sp_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         heading_ff   <= heading_in;
         sp_ff        <= sp_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_sym_ff   <= s1_sym_in;
      s2_cmd_ff   <= s2_cmd_in;
      s2_sym_ff   <= s2_sym_in;
      s2_dx_ff    <= s2_dx_in;
      s2_dy_ff    <= s2_dy_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Bracket stack of saved turtles.
   lsti_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/lsti_checker.sv
// Port-level assertions for the L-system turtle interpreter and their binding.
module lsti_checker
   import lsti_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   rsp_data_type rsp_view;

   assign rsp_view = rsp_tdata;

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or dropped while stalled");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A drawn segment carries its letter A to F.
   a_draw_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.action == ACT_DRAW |->
         rsp_view.segment_letter >= SYM_A && rsp_view.segment_letter <= SYM_F)
      else $error("draw result without a drawing letter");

   // Every other action carries no letter.
   a_other_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.action != ACT_DRAW |-> rsp_view.segment_letter == '0)
      else $error("letter set on a result that draws nothing");

   // Overflow happens only with a full stack and underflow only with an empty one.
   a_stack_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         !((rsp_view.action == ACT_OVERFLOW &&
            rsp_view.stack_level != LEVEL_W'(STACK_DEPTH)) ||
           (rsp_view.action == ACT_UNDERFLOW && rsp_view.stack_level != '0)))
      else $error("stack flag with an inconsistent stack level");

endmodule

bind lsystem_turtle_interpreter lsti_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_lsti_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/lsystem_turtle_interpreter_tb.sv
// Self-checking testbench for the L-system turtle interpreter.
module lsystem_turtle_interpreter_tb;
   import lsti_pkg::*;

   localparam longint Q30_ONE = 64'sd1 << 30;
   localparam longint PI_Q30  = 64'sd3373259426;
   localparam longint COORD_HI = 64'sd32767;
   localparam longint COORD_LO = -64'sd32768;

   // Expected turtle behavior, tracked one symbol at a time.
   class turtle_tracker;
      rsp_data_type expected_moves[$];
      int errors;
      int step_len;
      int turn_deg;
      longint pos_x;
      longint pos_y;
      int heading;
      int depth;
      longint saved_x[STACK_DEPTH_DEF];
      longint saved_y[STACK_DEPTH_DEF];
      int saved_h[STACK_DEPTH_DEF];
      longint sine_q15[91];

      function new();
         errors = 0;
         step_len = int'(STEP_RESET);
         turn_deg = int'(TURN_RESET);
         pos_x = 0;
         pos_y = 0;
         heading = 0;
         depth = 0;
         build_sine();
      endfunction

      // Quarter-wave table: Taylor series in Q30, rounded to Q15 with halves up.
      function void build_sine();
         longint x, x2, term, sum, v;
         int d, k;
         for (d = 0; d <= 90; d++) begin
            x = (longint'(d) * PI_Q30 + 90) / 180;
            x2 = x * x / Q30_ONE;
            term = x;
            sum = x;
            for (k = 1; k <= 10; k++) begin
               term = term * x2 / Q30_ONE / longint'((2 * k) * (2 * k + 1));
               if (k % 2 == 1) sum -= term;
               else sum += term;
            end
            if (sum < 0) sum = 0;
            v = (sum + (64'sd1 << 14)) / (64'sd1 << 15);
            if (v > (64'sd1 << 15)) v = 64'sd1 << 15;
            sine_q15[d] = v;
         end
      endfunction

      function longint sin_of(input int deg);
         int h;
         h = deg % 360;
         if (h <= 90) return sine_q15[h];
         if (h <= 180) return sine_q15[180 - h];
         if (h <= 270) return -sine_q15[h - 180];
         return -sine_q15[360 - h];
      endfunction

      // Step length times the sine, truncated toward zero.
      function longint step_offset(input longint s);
         longint mag, p;
         mag = (s < 0) ? -s : s;
         p = (longint'(step_len) * mag) / (64'sd1 << 15);
         return (s < 0) ? -p : p;
      endfunction

      function longint saturate_coord(input longint v);
         if (v > COORD_HI) return COORD_HI;
         if (v < COORD_LO) return COORD_LO;
         return v;
      endfunction

      function void write_register(input logic [CSR_ADDR_W-1:0] idx, input int value);
         if (idx == CSR_STEP_LENGTH) step_len = value & 10'h3FF;
         else if (idx == CSR_TURN_ANGLE) turn_deg = value & 9'h1FF;
      endfunction

      function int pending();
         return expected_moves.size();
      endfunction

      // Advance the turtle by one accepted symbol and queue the expected result.
      function void track_symbol(input logic [SYMBOL_W-1:0] sym);
         rsp_data_type exp;
         int turn;
         longint fx, fy;
         exp = '0;
         exp.action = ACT_NONE;
         turn = turn_deg % 360;
         fx = pos_x;
         fy = pos_y;
         if ((sym >= SYM_A && sym <= SYM_F) || sym == SYM_G) begin
            pos_x = saturate_coord(pos_x + step_offset(sin_of(heading)));
            pos_y = saturate_coord(pos_y + step_offset(sin_of(heading + 90)));
            if (sym == SYM_G) begin
               exp.action = ACT_MOVE;
            end else begin
               exp.action = ACT_DRAW;
               exp.segment_letter = sym;
            end
         end else if (sym == SYM_PLUS) begin
            heading = (heading + turn) % 360;
         end else if (sym == SYM_MINUS) begin
            heading = (heading + 360 - turn) % 360;
         end else if (sym == SYM_OPEN) begin
            if (depth >= STACK_DEPTH_DEF) begin
               exp.action = ACT_OVERFLOW;
            end else begin
               saved_x[depth] = pos_x;
               saved_y[depth] = pos_y;
               saved_h[depth] = heading;
               depth++;
            end
         end else if (sym == SYM_CLOSE) begin
            if (depth == 0) begin
               exp.action = ACT_UNDERFLOW;
            end else begin
               depth--;
               pos_x = saved_x[depth];
               pos_y = saved_y[depth];
               heading = saved_h[depth] % 360;
            end
         end
         exp.from_x = COORD_OUT_W'(fx);
         exp.from_y = COORD_OUT_W'(fy);
         exp.to_x = COORD_OUT_W'(pos_x);
         exp.to_y = COORD_OUT_W'(pos_y);
         exp.heading_deg = HEADING_W'(heading);
         exp.stack_level = LEVEL_W'(depth);
         expected_moves.push_back(exp);
      endfunction

      function void compare_field(input string name, input logic [15:0] exp,
                                  input logic [15:0] got);
         if (got !== exp) begin
            $error("%s: expected %0d, got %0d", name, exp, got);
            errors++;
         end
      endfunction

      // Compare one result transfer with the oldest expectation.
      function void check_move(input logic [RSP_DATA_W-1:0] data);
         rsp_data_type got, exp;
         got = rsp_data_type'(data);
         if (expected_moves.size() == 0) begin
            $error("result transfer with no symbol outstanding: %h", data);
            errors++;
            return;
         end
         exp = expected_moves.pop_front();
         compare_field("action", 16'(exp.action), 16'(got.action));
         compare_field("from_x", exp.from_x, got.from_x);
         compare_field("from_y", exp.from_y, got.from_y);
         compare_field("to_x", exp.to_x, got.to_x);
         compare_field("to_y", exp.to_y, got.to_y);
         compare_field("heading_deg", 16'(exp.heading_deg), 16'(got.heading_deg));
         compare_field("segment_letter", 16'(exp.segment_letter), 16'(got.segment_letter));
         compare_field("stack_level", 16'(exp.stack_level), 16'(got.stack_level));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SYMBOL_W-1:0]   req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int gap_pct = 0;
   int stall_pct = 0;
   turtle_tracker tracker;

   lsystem_turtle_interpreter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: check each transfer, then pick the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_move(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Offer one symbol, with an optional random gap first.
   task automatic send_symbol(input logic [SYMBOL_W-1:0] sym);
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sym;
      do @(posedge clock); while (!req_tready);
      tracker.track_symbol(sym);
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Write both registers while the block is idle and set the idling mix.
   task automatic configure(input int step, input int turn, input int gap, input int stall);
      hold_until_drained();
      csr_we <= 1'b1;
      csr_addr <= CSR_STEP_LENGTH;
      csr_wdata <= CSR_DATA_W'(step);
      @(posedge clock);
      csr_addr <= CSR_TURN_ANGLE;
      csr_wdata <= CSR_DATA_W'(turn);
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.write_register(CSR_STEP_LENGTH, step);
      tracker.write_register(CSR_TURN_ANGLE, turn);
      gap_pct = gap;
      stall_pct = stall;
   endtask

   // Mostly command symbols, with some arbitrary bytes as noise.
   function automatic logic [SYMBOL_W-1:0] pick_symbol();
      int r;
      r = $urandom_range(99);
      if (r < 30) return SYM_A + SYMBOL_W'($urandom_range(5));
      if (r < 38) return SYM_G;
      if (r < 50) return SYM_PLUS;
      if (r < 60) return SYM_MINUS;
      if (r < 72) return SYM_OPEN;
      if (r < 84) return SYM_CLOSE;
      return SYMBOL_W'($urandom_range(255));
   endfunction

   // Random strings, mostly made of bracketed branches.
   task automatic send_random(input int count);
      int sent, len, i;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) < 6) begin
            len = $urandom_range(1, 6);
            send_symbol(SYM_OPEN);
            for (i = 0; i < len; i++) send_symbol(pick_symbol());
            send_symbol(SYM_CLOSE);
            sent += len + 2;
         end else begin
            send_symbol(pick_symbol());
            sent++;
         end
      end
   endtask

   // Long straight runs in all four directions drive each coordinate into saturation.
   task automatic send_straight_runs(input int run_len);
      int side, i;
      for (side = 0; side < 4; side++) begin
         for (i = 0; i < run_len; i++) send_symbol(SYM_F);
         send_symbol(SYM_PLUS);
      end
   endtask

   // Fill the stack past its depth, then unwind past empty.
   task automatic send_stack_burst();
      int i;
      for (i = 0; i < STACK_DEPTH_DEF + 2; i++) begin
         if ($urandom_range(3) == 0) send_symbol(SYM_G);
         send_symbol(SYM_OPEN);
      end
      for (i = 0; i < STACK_DEPTH_DEF + 3; i++) send_symbol(SYM_CLOSE);
   endtask

   task automatic send_opening();
      logic [SYMBOL_W-1:0] seq [25] = '{
         SYM_CLOSE, SYM_A, SYM_PLUS, SYM_A + 8'd1, SYM_PLUS, SYM_A + 8'd2, SYM_PLUS,
         SYM_A + 8'd3, SYM_PLUS, SYM_A + 8'd4, SYM_MINUS, SYM_F, SYM_G, SYM_OPEN,
         SYM_PLUS, SYM_F, SYM_OPEN, SYM_MINUS, SYM_G, SYM_CLOSE, SYM_CLOSE,
         8'h00, 8'hFF, 8'h7F, 8'h61
      };
      foreach (seq[i]) send_symbol(seq[i]);
   endtask

   initial begin
      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Register defaults after reset, no idling.
      send_opening();

      configure(1023, 90, 0, 0);
      send_straight_runs(70);

      configure(0, 0, 70, 0);
      send_random(140);

      configure(1, 359, 0, 70);
      send_stack_burst();
      send_random(100);

      configure(777, 450, 19, 19);
      send_random(80);
      hold_until_drained();
      send_random(80);

      configure(511, 511, 0, 0);
      send_random(130);

      configure(37, 25, 70, 0);
      send_random(120);

      configure(1023, 1, 0, 70);
      send_random(120);

      configure(300, 60, 19, 19);
      send_stack_burst();
      send_random(40);

      hold_until_drained();
      repeat (8) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("lsystem_turtle_interpreter_tb OK");
      end else begin
         $display("lsystem_turtle_interpreter_tb NOT OK");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #2000000;
      $display("lsystem_turtle_interpreter_tb NOT OK");
      $finish;
   end

endmodule

>>> filelist.f
rtl/lsti_pkg.sv
rtl/lsti_ram.sv
rtl/lsystem_turtle_interpreter.sv
rtl/lsti_checker.sv
tb/lsystem_turtle_interpreter_tb.sv
